// ----- rtl/emg_rep_pkg.sv -----
// shared types, constants and register codes for the emg repetition pulse counter
`default_nettype none

package emg_rep_pkg;

   // default parameter values
   localparam int unsigned READS_PER_SAMPLE_DEFAULT = 4;
   localparam int unsigned TICK_BITS_DEFAULT        = 16;
   localparam int unsigned ADC_BITS_DEFAULT         = 12;

   // field widths
   localparam int unsigned THRESHOLD_BITS = 12;
   localparam int unsigned PERIOD_BITS    = 8;
   localparam int unsigned MIN_PULSE_BITS = 16;
   localparam int unsigned SAMPLE_BITS    = 12;
   localparam int unsigned WIDTH_MS_BITS  = 24;
   localparam int unsigned REP_BITS       = 16;
   localparam int unsigned CSR_INDEX_BITS = 2;
   localparam int unsigned CSR_DATA_BITS  = 16;

   // register indexes
   localparam logic [CSR_INDEX_BITS-1:0] CSR_THRESHOLD_HIGH = 2'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_THRESHOLD_LOW  = 2'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_TICK_PERIOD_MS = 2'd2;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_MIN_PULSE_MS   = 2'd3;

   // register reset values
   localparam logic [THRESHOLD_BITS-1:0] THRESHOLD_HIGH_RESET = 12'd1900;
   localparam logic [THRESHOLD_BITS-1:0] THRESHOLD_LOW_RESET  = 12'd900;
   localparam logic [PERIOD_BITS-1:0]    TICK_PERIOD_RESET    = 8'd20;
   localparam logic [MIN_PULSE_BITS-1:0] MIN_PULSE_RESET      = 16'd250;

   typedef struct packed {
      logic [THRESHOLD_BITS-1:0] threshold_high;
      logic [THRESHOLD_BITS-1:0] threshold_low;
      logic [PERIOD_BITS-1:0]    tick_period_ms;
      logic [MIN_PULSE_BITS-1:0] min_pulse_ms;
   } cfg_type;

   typedef struct packed {
      logic                     pulse_started;
      logic [WIDTH_MS_BITS-1:0] dead_width_ms;
      logic                     rep_counted;
      logic [WIDTH_MS_BITS-1:0] pulse_width_ms;
      logic [REP_BITS-1:0]      rep_total;
      logic                     active_rep;
   } pulse_result_type;

endpackage

`default_nettype wire

// ----- rtl/emg_rep_avg.sv -----
// accumulates raw readings and produces the floor mean of each group
`default_nettype none

module emg_rep_avg #(
   parameter int unsigned READS_PER_SAMPLE = emg_rep_pkg::READS_PER_SAMPLE_DEFAULT,
   parameter int unsigned ADC_BITS         = emg_rep_pkg::ADC_BITS_DEFAULT
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                enable,
   input  wire logic [ADC_BITS-1:0] reading,
   output logic                     sample_valid,
   output logic [ADC_BITS-1:0]      sample
);
   import emg_rep_pkg::*;

   localparam int unsigned LOG_R = $clog2(READS_PER_SAMPLE);
   localparam int unsigned SUM_W = ADC_BITS + LOG_R;
   localparam int unsigned IDX_W = (LOG_R > 0) ? LOG_R : 1;
   localparam int unsigned SHIFT = SUM_W + LOG_R;
   localparam int unsigned MUL_W = SUM_W + 2;
   localparam int unsigned PROD_W = SUM_W + MUL_W;
   // ceil(2^SHIFT / R): exact floor quotient for every sum below 2^SUM_W
   localparam logic [MUL_W-1:0] RECIP =
      MUL_W'(((64'd1 << SHIFT) + 64'(READS_PER_SAMPLE) - 64'd1) / 64'(READS_PER_SAMPLE));
   localparam logic [IDX_W-1:0] LAST_INDEX = IDX_W'(READS_PER_SAMPLE - 1);

   logic [SUM_W-1:0]  read_sum_ff, read_sum_in;
   logic [IDX_W-1:0]  read_index_ff, read_index_in;
   logic [SUM_W-1:0]  sum_total;
   logic [PROD_W-1:0] product;
   logic              last;

   assign sum_total = read_sum_ff + SUM_W'(reading);
   assign last      = (read_index_ff == LAST_INDEX);
   assign product   = PROD_W'(sum_total) * PROD_W'(RECIP);

   assign sample_valid = last;
   assign sample       = product[SHIFT +: ADC_BITS];

   always_comb begin
      read_sum_in   = read_sum_ff;
      read_index_in = read_index_ff;
      if (enable) begin
         if (last) begin
            read_sum_in   = '0;
            read_index_in = '0;
         end else begin
            read_sum_in   = sum_total;
            read_index_in = read_index_ff + IDX_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         read_sum_ff   <= '0;
         read_index_ff <= '0;
      end else begin
         read_sum_ff   <= read_sum_in;
         read_index_ff <= read_index_in;
      end
   end

endmodule

`default_nettype wire

// ----- rtl/emg_rep_pulse.sv -----
// classifies averaged samples, keeps pulse and dead tick counters, counts repetitions
`default_nettype none

module emg_rep_pulse #(
   parameter int unsigned TICK_BITS = emg_rep_pkg::TICK_BITS_DEFAULT,
   parameter int unsigned ADC_BITS  = emg_rep_pkg::ADC_BITS_DEFAULT
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           enable,
   input  wire logic                           sample_valid,
   input  wire logic [ADC_BITS-1:0]            sample,
   input  wire emg_rep_pkg::cfg_type           cfg,
   output emg_rep_pkg::pulse_result_type       result
);
   import emg_rep_pkg::*;

   localparam int unsigned CMP_W  = (ADC_BITS > THRESHOLD_BITS) ? ADC_BITS : THRESHOLD_BITS;
   localparam int unsigned PROD_W = TICK_BITS + PERIOD_BITS;

   logic                 in_rep_ff, in_rep_in;
   logic [ADC_BITS-1:0]  prev_sample_ff, prev_sample_in;
   logic                 prev_seen_ff, prev_seen_in;
   logic [TICK_BITS-1:0] pulse_ticks_ff, pulse_ticks_in;
   logic [TICK_BITS-1:0] dead_ticks_ff, dead_ticks_in;
   logic [REP_BITS-1:0]  rep_counter_ff, rep_counter_in;

   logic [CMP_W-1:0]     samp_cmp, prev_cmp, thr_high, thr_low;
   logic [PROD_W-1:0]    dead_prod, pulse_prod;
   logic [TICK_BITS-1:0] pulse_inc, dead_inc;
   logic [REP_BITS-1:0]  rep_inc;
   logic                 started, counted;

   assign samp_cmp = CMP_W'(sample);
   assign prev_cmp = CMP_W'(prev_sample_ff);
   assign thr_high = CMP_W'(cfg.threshold_high);
   assign thr_low  = CMP_W'(cfg.threshold_low);

   assign dead_prod  = PROD_W'(dead_ticks_ff) * PROD_W'(cfg.tick_period_ms);
   assign pulse_prod = PROD_W'(pulse_ticks_ff) * PROD_W'(cfg.tick_period_ms);

   // saturating increments
   assign pulse_inc = (&pulse_ticks_ff) ? pulse_ticks_ff : pulse_ticks_ff + TICK_BITS'(1);
   assign dead_inc  = (&dead_ticks_ff) ? dead_ticks_ff : dead_ticks_ff + TICK_BITS'(1);
   assign rep_inc   = (&rep_counter_ff) ? rep_counter_ff : rep_counter_ff + REP_BITS'(1);

   always_comb begin
      in_rep_in      = in_rep_ff;
      prev_sample_in = prev_sample_ff;
      prev_seen_in   = prev_seen_ff;
      pulse_ticks_in = pulse_ticks_ff;
      dead_ticks_in  = dead_ticks_ff;
      rep_counter_in = rep_counter_ff;
      started        = 1'b0;
      counted        = 1'b0;
      if (sample_valid) begin
         prev_seen_in   = 1'b1;
         prev_sample_in = sample;
         if (samp_cmp >= thr_high) begin
            // pulse starts only from a previous sample at or above the low level
            if (prev_seen_ff && (prev_cmp >= thr_low)) begin
               in_rep_in      = 1'b1;
               started        = 1'b1;
               dead_ticks_in  = '0;
               pulse_ticks_in = pulse_inc;
            end
         end else if (samp_cmp >= thr_low) begin
            if (in_rep_ff) begin
               pulse_ticks_in = pulse_inc;
            end else begin
               dead_ticks_in = dead_inc;
            end
         end else begin
            // rest sample is kept as zero, so a run of them acts once
            if (prev_seen_ff && (prev_sample_ff != '0)) begin
               in_rep_in      = 1'b0;
               pulse_ticks_in = '0;
               dead_ticks_in  = dead_inc;
               if (pulse_prod > PROD_W'(cfg.min_pulse_ms)) begin
                  rep_counter_in = rep_inc;
                  counted        = 1'b1;
               end
            end
            prev_sample_in = '0;
         end
      end
   end

   always_comb begin
      result.pulse_started  = started;
      result.dead_width_ms  = started ? WIDTH_MS_BITS'(dead_prod) : '0;
      result.rep_counted    = counted;
      result.pulse_width_ms = counted ? WIDTH_MS_BITS'(pulse_prod) : '0;
      result.rep_total      = rep_counter_in;
      result.active_rep     = in_rep_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_rep_ff      <= 1'b0;
         prev_sample_ff <= '0;
         prev_seen_ff   <= 1'b0;
         pulse_ticks_ff <= '0;
         dead_ticks_ff  <= '0;
         rep_counter_ff <= '0;
      end else if (enable) begin
         in_rep_ff      <= in_rep_in;
         prev_sample_ff <= prev_sample_in;
         prev_seen_ff   <= prev_seen_in;
         pulse_ticks_ff <= pulse_ticks_in;
         dead_ticks_ff  <= dead_ticks_in;
         rep_counter_ff <= rep_counter_in;
      end
   end

   // entering a repetition always clears the dead count
   a_start_clears_dead: assert property (@(posedge clock) disable iff (reset)
      !$past(reset) && $rose(in_rep_ff) |-> dead_ticks_ff == '0)
      else $error("repetition entered with nonzero dead ticks");

   // repetition count never goes down
   a_rep_monotonic: assert property (@(posedge clock) disable iff (reset)
      !$past(reset) |-> rep_counter_ff >= $past(rep_counter_ff))
      else $error("repetition count decreased");

   // outside a repetition no pulse ticks are held
   a_idle_no_pulse: assert property (@(posedge clock) disable iff (reset)
      !in_rep_ff |-> pulse_ticks_ff == '0)
      else $error("pulse ticks held outside a repetition");

endmodule

`default_nettype wire

// ----- rtl/emg_rep_pulse_counter_core.sv -----
// top level of the emg repetition pulse counter: handshakes, config registers, result register
//
//  channel   direction  handshake            payload
//  req       in         req_valid/req_stall  req_adc_reading
//  rsp       out        rsp_valid/rsp_stall  sample, pulse, rep fields
//  csr       in         csr_write_enable     csr_index, csr_write_data
//
// one transfer per cycle sustained while rsp_stall is low; a reading goes from its req transfer to rsp
// by the path input register, average and classify logic, result register
// reset is synchronous and clears counters, flags and both valid registers
// rsp_stall holds the result register and then the input register, then req_stall rises
`default_nettype none

module emg_rep_pulse_counter_core #(
   parameter int unsigned READS_PER_SAMPLE = emg_rep_pkg::READS_PER_SAMPLE_DEFAULT,
   parameter int unsigned TICK_BITS        = emg_rep_pkg::TICK_BITS_DEFAULT,
   parameter int unsigned ADC_BITS         = emg_rep_pkg::ADC_BITS_DEFAULT
) (
   input  wire logic                                        clock,
   input  wire logic                                        reset,
   input  wire logic                                        req_valid,
   output logic                                             req_stall,
   input  wire logic [ADC_BITS-1:0]                         req_adc_reading,
   output logic                                             rsp_valid,
   input  wire logic                                        rsp_stall,
   output logic                                             rsp_sample_ready,
   output logic [emg_rep_pkg::SAMPLE_BITS-1:0]              rsp_averaged_sample,
   output logic                                             rsp_pulse_started,
   output logic [emg_rep_pkg::WIDTH_MS_BITS-1:0]            rsp_dead_width_ms,
   output logic                                             rsp_rep_counted,
   output logic [emg_rep_pkg::WIDTH_MS_BITS-1:0]            rsp_pulse_width_ms,
   output logic [emg_rep_pkg::REP_BITS-1:0]                 rsp_rep_total,
   output logic                                             rsp_active_rep,
   input  wire logic                                        csr_write_enable,
   input  wire logic [emg_rep_pkg::CSR_INDEX_BITS-1:0]      csr_index,
   input  wire logic [emg_rep_pkg::CSR_DATA_BITS-1:0]       csr_write_data
);
   import emg_rep_pkg::*;

   localparam int unsigned EXT_W = (ADC_BITS > SAMPLE_BITS) ? ADC_BITS : SAMPLE_BITS;

   cfg_type             cfg_ff, cfg_in;
   logic                in_valid_ff, in_valid_in;
   logic [ADC_BITS-1:0] in_reading_ff;
   logic                out_valid_ff, out_valid_in;
   logic                advance;

   logic                sample_valid;
   logic [ADC_BITS-1:0] sample;
   logic [EXT_W-1:0]    sample_ext;
   pulse_result_type    result;

   logic                   sample_ready_ff;
   logic [SAMPLE_BITS-1:0] averaged_sample_ff;
   pulse_result_type       result_ff;

   // item moves into the result register when that register is free or draining
   assign advance   = in_valid_ff && (!out_valid_ff || !rsp_stall);
   assign req_stall = in_valid_ff && !advance;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_enable) begin
         case (csr_index)
            CSR_THRESHOLD_HIGH: cfg_in.threshold_high = csr_write_data[THRESHOLD_BITS-1:0];
            CSR_THRESHOLD_LOW:  cfg_in.threshold_low  = csr_write_data[THRESHOLD_BITS-1:0];
            CSR_TICK_PERIOD_MS: cfg_in.tick_period_ms = csr_write_data[PERIOD_BITS-1:0];
            CSR_MIN_PULSE_MS:   cfg_in.min_pulse_ms   = csr_write_data[MIN_PULSE_BITS-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.threshold_high <= THRESHOLD_HIGH_RESET;
         cfg_ff.threshold_low  <= THRESHOLD_LOW_RESET;
         cfg_ff.tick_period_ms <= TICK_PERIOD_RESET;
         cfg_ff.min_pulse_ms   <= MIN_PULSE_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   emg_rep_avg #(
      .READS_PER_SAMPLE (READS_PER_SAMPLE),
      .ADC_BITS         (ADC_BITS)
   ) u_avg (
      .clock        (clock),
      .reset        (reset),
      .enable       (advance),
      .reading      (in_reading_ff),
      .sample_valid (sample_valid),
      .sample       (sample)
   );

   emg_rep_pulse #(
      .TICK_BITS (TICK_BITS),
      .ADC_BITS  (ADC_BITS)
   ) u_pulse (
      .clock        (clock),
      .reset        (reset),
      .enable       (advance),
      .sample_valid (sample_valid),
      .sample       (sample),
      .cfg          (cfg_ff),
      .result       (result)
   );

   assign sample_ext = EXT_W'(sample);

   assign in_valid_in  = req_stall ? in_valid_ff : req_valid;
   assign out_valid_in = advance ? 1'b1 : (out_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         in_reading_ff <= req_adc_reading;
      end
      if (advance) begin
         sample_ready_ff    <= sample_valid;
         averaged_sample_ff <= sample_valid ? sample_ext[SAMPLE_BITS-1:0] : '0;
         result_ff          <= result;
      end
   end

   assign rsp_valid           = out_valid_ff;
   assign rsp_sample_ready    = sample_ready_ff;
   assign rsp_averaged_sample = averaged_sample_ff;
   assign rsp_pulse_started   = result_ff.pulse_started;
   assign rsp_dead_width_ms   = result_ff.dead_width_ms;
   assign rsp_rep_counted     = result_ff.rep_counted;
   assign rsp_pulse_width_ms  = result_ff.pulse_width_ms;
   assign rsp_rep_total       = result_ff.rep_total;
   assign rsp_active_rep      = result_ff.active_rep;

   // pulse events only happen on a completed sample
   a_events_need_sample: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && (result_ff.rep_counted || result_ff.pulse_started) |-> sample_ready_ff)
      else $error("pulse event without a completed sample");

   // a started pulse leaves the block inside a repetition
   a_start_is_active: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && result_ff.pulse_started |-> result_ff.active_rep)
      else $error("pulse start reported outside a repetition");

   // a held input item stays in the input register until it moves on
   a_input_held: assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && !advance |=> in_valid_ff && $stable(in_reading_ff))
      else $error("input item lost while waiting");

endmodule

`default_nettype wire

// ----- tb/emg_rep_pulse_counter_core_tb.sv -----
// self-checking testbench for the emg repetition pulse counter core
`default_nettype none

module emg_rep_pulse_counter_core_tb;
   import emg_rep_pkg::*;

   typedef struct packed {
      logic                   sample_ready;
      logic [SAMPLE_BITS-1:0] averaged_sample;
      pulse_result_type       pulse;
   } rep_result_type;

   typedef enum int {LEVEL_REST, LEVEL_MID, LEVEL_HIGH} level_kind_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                          req_valid = 1'b0;
   logic                          req_stall;
   logic [ADC_BITS_DEFAULT-1:0]   req_adc_reading = '0;
   logic                          rsp_valid;
   logic                          rsp_stall = 1'b0;
   logic                          rsp_sample_ready;
   logic [SAMPLE_BITS-1:0]        rsp_averaged_sample;
   logic                          rsp_pulse_started;
   logic [WIDTH_MS_BITS-1:0]      rsp_dead_width_ms;
   logic                          rsp_rep_counted;
   logic [WIDTH_MS_BITS-1:0]      rsp_pulse_width_ms;
   logic [REP_BITS-1:0]           rsp_rep_total;
   logic                          rsp_active_rep;
   logic                          csr_write_enable = 1'b0;
   logic [CSR_INDEX_BITS-1:0]     csr_index = '0;
   logic [CSR_DATA_BITS-1:0]      csr_write_data = '0;

   // predictor state and its copy of the registers
   cfg_type        cfg = '{THRESHOLD_HIGH_RESET, THRESHOLD_LOW_RESET,
                           TICK_PERIOD_RESET, MIN_PULSE_RESET};
   logic [13:0]    group_sum = '0;
   logic [1:0]     group_count = '0;
   logic           in_pulse = 1'b0;
   logic [11:0]    last_level = '0;
   logic           level_seen = 1'b0;
   logic [15:0]    active_ticks = '0;
   logic [15:0]    rest_ticks = '0;
   logic [15:0]    rep_count = '0;

   logic [11:0]    pending_readings [$];
   rep_result_type expected_results [$];

   int   mismatch_count = 0;
   int   fill_count = 0;
   logic calm = 1'b0;
   logic hold_req = 1'b0;
   logic hold_done = 1'b0;
   int   hold_cnt = 0;

   emg_rep_pulse_counter_core dut (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_adc_reading     (req_adc_reading),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_sample_ready    (rsp_sample_ready),
      .rsp_averaged_sample (rsp_averaged_sample),
      .rsp_pulse_started   (rsp_pulse_started),
      .rsp_dead_width_ms   (rsp_dead_width_ms),
      .rsp_rep_counted     (rsp_rep_counted),
      .rsp_pulse_width_ms  (rsp_pulse_width_ms),
      .rsp_rep_total       (rsp_rep_total),
      .rsp_active_rep      (rsp_active_rep),
      .csr_write_enable    (csr_write_enable),
      .csr_index           (csr_index),
      .csr_write_data      (csr_write_data)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   function automatic logic [15:0] bump(input logic [15:0] v);
      return (v == 16'hFFFF) ? v : v + 16'd1;
   endfunction

   function rep_result_type track_reading(input logic [11:0] reading);
      rep_result_type res;
      logic [13:0]    total;
      logic [11:0]    level;
      logic [23:0]    width;
      res = '0;
      total = group_sum + 14'(reading);
      if (group_count == 2'd3) begin
         level = total[13:2];
         group_sum = '0;
         group_count = '0;
         res.sample_ready = 1'b1;
         res.averaged_sample = level;
         if (level >= cfg.threshold_high) begin
            if (level_seen && last_level >= cfg.threshold_low) begin
               in_pulse = 1'b1;
               res.pulse.pulse_started = 1'b1;
               res.pulse.dead_width_ms = 24'(rest_ticks) * 24'(cfg.tick_period_ms);
               rest_ticks = '0;
               active_ticks = bump(active_ticks);
            end
         end else if (level >= cfg.threshold_low) begin
            if (in_pulse) active_ticks = bump(active_ticks);
            else rest_ticks = bump(rest_ticks);
         end else begin
            if (level_seen && last_level != 12'd0) begin
               width = 24'(active_ticks) * 24'(cfg.tick_period_ms);
               in_pulse = 1'b0;
               active_ticks = '0;
               rest_ticks = bump(rest_ticks);
               if (width > 24'(cfg.min_pulse_ms)) begin
                  rep_count = bump(rep_count);
                  res.pulse.rep_counted = 1'b1;
                  res.pulse.pulse_width_ms = width;
               end
            end
            level = '0;
         end
         last_level = level;
         level_seen = 1'b1;
      end else begin
         group_sum = total;
         group_count = group_count + 2'd1;
      end
      res.pulse.rep_total = rep_count;
      res.pulse.active_rep = in_pulse;
      return res;
   endfunction

   task report_mismatch(input string what, input logic [23:0] got, input logic [23:0] want);
      mismatch_count++;
      if (mismatch_count <= 100)
         $display("%0t %s: got %0d want %0d", $realtime, what, got, want);
   endtask

   task check_field(input string what, input logic [23:0] got, input logic [23:0] want);
      if (got !== want) report_mismatch(what, got, want);
   endtask

   // driver: one transfer per accepted reading, predictions taken at the transfer
   always @(posedge clock) begin : drive
      logic idle;
      idle = !calm && hold_cnt == 0 && $urandom_range(0, 99) < 26;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall)
            expected_results.push_back(track_reading(req_adc_reading));
         if (!req_valid || !req_stall) begin
            if (pending_readings.size() != 0 && !idle) begin
               req_valid <= 1'b1;
               req_adc_reading <= pending_readings.pop_front();
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // long receiver hold-off
   always @(posedge clock) begin
      if (!reset) begin
         if (hold_cnt != 0) begin
            hold_cnt <= hold_cnt - 1;
         end else if (hold_req && !hold_done) begin
            hold_cnt <= 80;
            hold_done <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin : watch
      rep_result_type got;
      rep_result_type want;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            got.sample_ready          = rsp_sample_ready;
            got.averaged_sample       = rsp_averaged_sample;
            got.pulse.pulse_started   = rsp_pulse_started;
            got.pulse.dead_width_ms   = rsp_dead_width_ms;
            got.pulse.rep_counted     = rsp_rep_counted;
            got.pulse.pulse_width_ms  = rsp_pulse_width_ms;
            got.pulse.rep_total       = rsp_rep_total;
            got.pulse.active_rep      = rsp_active_rep;
            if (expected_results.size() == 0) begin
               report_mismatch("result with no reading pending",
                               24'(got.averaged_sample), 24'd0);
            end else begin
               want = expected_results.pop_front();
               check_field("sample_ready", 24'(got.sample_ready), 24'(want.sample_ready));
               check_field("averaged_sample", 24'(got.averaged_sample),
                           24'(want.averaged_sample));
               check_field("pulse_started", 24'(got.pulse.pulse_started),
                           24'(want.pulse.pulse_started));
               check_field("dead_width_ms", got.pulse.dead_width_ms, want.pulse.dead_width_ms);
               check_field("rep_counted", 24'(got.pulse.rep_counted),
                           24'(want.pulse.rep_counted));
               check_field("pulse_width_ms", got.pulse.pulse_width_ms,
                           want.pulse.pulse_width_ms);
               check_field("rep_total", 24'(got.pulse.rep_total), 24'(want.pulse.rep_total));
               check_field("active_rep", 24'(got.pulse.active_rep),
                           24'(want.pulse.active_rep));
            end
         end
         rsp_stall <= (hold_cnt != 0) || (!calm && $urandom_range(0, 99) < 26);
      end
   end

   task write_reg(input logic [CSR_INDEX_BITS-1:0] idx, input logic [CSR_DATA_BITS-1:0] val);
      @(posedge clock);
      csr_write_enable <= 1'b1;
      csr_index <= idx;
      csr_write_data <= val;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      case (idx)
         CSR_THRESHOLD_HIGH: cfg.threshold_high = val[11:0];
         CSR_THRESHOLD_LOW:  cfg.threshold_low = val[11:0];
         CSR_TICK_PERIOD_MS: cfg.tick_period_ms = val[7:0];
         CSR_MIN_PULSE_MS:   cfg.min_pulse_ms = val;
         default: ;
      endcase
   endtask

   task apply_setting(input int high, input int low, input int period, input int min_ms);
      write_reg(CSR_THRESHOLD_HIGH, 16'(high));
      write_reg(CSR_THRESHOLD_LOW, 16'(low));
      write_reg(CSR_TICK_PERIOD_MS, 16'(period));
      write_reg(CSR_MIN_PULSE_MS, 16'(min_ms));
   endtask

   task wait_idle();
      do @(posedge clock);
      while (pending_readings.size() != 0 || req_valid || expected_results.size() != 0);
      repeat (4) @(posedge clock);
   endtask

   function automatic int clamp_reading(input int v);
      return (v < 0) ? 0 : (v > 4095) ? 4095 : v;
   endfunction

   // four readings whose floor mean lands near the given level
   task push_sample(input int level);
      int acc;
      int k;
      int v;
      acc = 0;
      for (k = 0; k < 3; k++) begin
         v = clamp_reading(level + int'($urandom_range(0, 16)) - 8);
         pending_readings.push_back(v[11:0]);
         acc += v;
      end
      v = clamp_reading(4 * level + int'($urandom_range(0, 3)) - acc);
      pending_readings.push_back(v[11:0]);
      fill_count += 4;
   endtask

   function automatic int pick_level(input level_kind_type kind);
      case (kind)
         LEVEL_HIGH: return int'($urandom_range(4095, int'(cfg.threshold_high)));
         LEVEL_MID:
            if (cfg.threshold_low < cfg.threshold_high)
               return int'($urandom_range(int'(cfg.threshold_high) - 1, int'(cfg.threshold_low)));
            else
               return int'($urandom_range(4095, 0));
         default:
            if (cfg.threshold_low == 0 || $urandom_range(0, 3) == 0) return 0;
            else return int'($urandom_range(int'(cfg.threshold_low) - 1, 0));
      endcase
   endfunction

   task push_run(input level_kind_type kind, input int lo, input int hi);
      repeat ($urandom_range(hi, lo)) push_sample(pick_level(kind));
   endtask

   initial begin : stimulus
      logic [11:0] first_items [] = '{
         12'd4095, 12'd4095, 12'd4095, 12'd4095,
         12'd0, 12'd0, 12'd0, 12'd0,
         12'd0, 12'd0, 12'd0, 12'd0,
         12'd4095, 12'd4095, 12'd4095, 12'd4095,
         12'd1000, 12'd1001, 12'd1001, 12'd1001,
         12'd4095, 12'd4095, 12'd4095, 12'd4092};
      int phase;
      int pick;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // high before any sample, rest runs, high after rest, floor mean, pulse start
      foreach (first_items[i]) pending_readings.push_back(first_items[i]);
      wait_idle();

      for (phase = 0; phase < 8; phase++) begin
         case (phase)
            0: apply_setting(1900, 900, 20, 250);
            1: apply_setting(500, 3000, 20, 100);
            2: apply_setting(0, 0, 1, 0);
            3: apply_setting(4095, 4095, 255, 65535);
            4: apply_setting(2500, 1200, 0, 250);
            5: apply_setting(3000, 1000, 5, 40);
            6: begin
               write_reg(CSR_THRESHOLD_HIGH, 16'($urandom_range(0, 65535)));
               write_reg(CSR_THRESHOLD_LOW, 16'($urandom_range(0, 65535)));
               write_reg(CSR_TICK_PERIOD_MS, 16'($urandom_range(0, 65535)));
               write_reg(CSR_MIN_PULSE_MS, 16'($urandom_range(0, 65535)));
            end
            default: apply_setting(1200, 600, 255, 2000);
         endcase
         // no idling on either side for the first phase
         calm <= (phase == 0);
         fill_count = 0;
         while (fill_count < 72) begin
            pick = $urandom_range(0, 99);
            if (pick < 70) begin
               push_run(LEVEL_REST, 1, 3);
               push_run(LEVEL_MID, 1, 3);
               push_run(LEVEL_HIGH, 1, 20);
               push_run(LEVEL_MID, 0, 4);
               push_run(LEVEL_REST, 1, 2);
            end else if (pick < 85) begin
               repeat (4) pending_readings.push_back(12'($urandom_range(0, 4095)));
               fill_count += 4;
            end else begin
               // high straight after rest must not start a pulse
               push_run(LEVEL_REST, 1, 2);
               push_run(LEVEL_HIGH, 1, 2);
               push_run(LEVEL_MID, 0, 2);
            end
         end
         if (phase == 1) begin
            @(posedge clock);
            hold_req <= 1'b1;
         end
         wait_idle();
      end

      repeat (8) @(posedge clock);
      if (mismatch_count == 0)
         $display("emg_rep_pulse_counter_core: match");
      else
         $display("emg_rep_pulse_counter_core: mismatch");
      $finish;
   end

   initial begin
      #240000;
      $display("emg_rep_pulse_counter_core: mismatch");
      $finish;
   end

endmodule

`default_nettype wire
